// ----- rtl/rbsh_pkg.sv -----
// shared types and constants for the ray box slab hit block
// no dependencies; imported by every rbsh module and ray_box_slab_hit

package rbsh_pkg;

	localparam int DIST_W   = 16;
	localparam int BOX_W    = 9;
	localparam int SHIFT_W  = 4;
	// multiplier factor: covers 256 - reg (down to -255) and reg (up to 511)
	localparam int K_W      = 11;
	localparam int PROD_W   = DIST_W + K_W;
	localparam int FRAC_W   = 8;

	localparam int S_DATA_W = 104;
	localparam int M_DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [DIST_W-1:0]  DIST_NEVER = 16'hffff;
	localparam logic [K_W-1:0]     FULL_FACE  = 11'd256;
	localparam logic [BOX_W-1:0]   BOX_LOW_RST  = 9'd96;
	localparam logic [BOX_W-1:0]   BOX_HIGH_RST = 9'd160;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y_HIGH = 2'd3;

	// per-axis products and parallel-axis range check, registered between stages
	typedef struct packed {
		logic              par;
		logic              par_ok;
		logic [DIST_W-1:0] to_in;
		logic [DIST_W-1:0] to_out;
	} slab_pre_t;

	// per-axis slab interval
	typedef struct packed {
		logic              ok;
		logic [DIST_W-1:0] dist_in;
		logic [DIST_W-1:0] dist_out;
	} slab_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] rel_pos_y;
		logic signed [DIST_W-1:0] rel_pos_x;
		logic                     dir_y_zero;
		logic                     dir_x_zero;
		logic                     step_y_negative;
		logic                     step_x_negative;
		logic [DIST_W-1:0]        delta_y;
		logic [DIST_W-1:0]        delta_x;
		logic [DIST_W-1:0]        side_dist_y;
		logic [DIST_W-1:0]        side_dist_x;
	} in_item_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] face_shift;
		logic [BOX_W-1:0]   face_low;
		logic               hit_side;
		logic [DIST_W-1:0]  entry_dist;
		logic               hit;
	} out_item_t;

endpackage

// ----- rtl/rbsh_slab_pre.sv -----
// first half of one axis slab: box face distances from the per-cell delta
// depends on rbsh_pkg

module rbsh_slab_pre
	import rbsh_pkg::*;
(
	input  logic [DIST_W-1:0]        delta,
	input  logic                     step_negative,
	input  logic                     dir_zero,
	input  logic signed [DIST_W-1:0] rel_pos,
	input  logic [BOX_W-1:0]         box_low,
	input  logic [BOX_W-1:0]         box_high,
	output slab_pre_t                pre
);

	logic signed [K_W-1:0]    k_in;
	logic signed [K_W-1:0]    k_out;
	logic signed [PROD_W-1:0] p_in;
	logic signed [PROD_W-1:0] p_out;
	logic signed [DIST_W:0]   pos_w;
	logic signed [DIST_W:0]   low_w;
	logic signed [DIST_W:0]   high_w;

	// plus direction enters at the far side of the cell minus low
	always_comb begin
		if (step_negative) begin
			k_in  = $signed({2'b00, box_high});
			k_out = $signed({2'b00, box_low});
		end else begin
			k_in  = $signed(FULL_FACE - {2'b00, box_low});
			k_out = $signed(FULL_FACE - {2'b00, box_high});
		end
	end

	// delta is taken as signed 16-bit
	assign p_in  = $signed(delta) * k_in;
	assign p_out = $signed(delta) * k_out;

	assign pos_w  = {rel_pos[DIST_W-1], rel_pos};
	assign low_w  = $signed({{(DIST_W+1-BOX_W){1'b0}}, box_low});
	assign high_w = $signed({{(DIST_W+1-BOX_W){1'b0}}, box_high});

	always_comb begin
		pre.par    = dir_zero;
		pre.par_ok = (pos_w >= low_w) && (pos_w < high_w);
		pre.to_in  = p_in[FRAC_W +: DIST_W];
		pre.to_out = p_out[FRAC_W +: DIST_W];
	end

endmodule

// ----- rtl/rbsh_slab_cmp.sv -----
// second half of one axis slab: entry and exit distances against the cell side distance
// depends on rbsh_pkg

module rbsh_slab_cmp
	import rbsh_pkg::*;
(
	input  logic [DIST_W-1:0] side_dist,
	input  slab_pre_t         pre,
	output slab_t             res
);

	always_comb begin
		if (pre.par) begin
			res.ok       = pre.par_ok;
			res.dist_in  = '0;
			res.dist_out = DIST_NEVER;
		end else begin
			res.ok       = side_dist > pre.to_out;
			// entry behind the origin clamps to zero
			res.dist_in  = (side_dist > pre.to_in) ? (side_dist - pre.to_in) : '0;
			res.dist_out = side_dist - pre.to_out;
		end
	end

endmodule

// ----- rtl/ray_box_slab_hit.sv -----
// top level of the ray box slab hit block: stream ports, box registers, pipeline
// depends on rbsh_pkg, rbsh_slab_pre, rbsh_slab_cmp

// Tests one grid ray against an axis-aligned box inside a map cell, using
// 8.8 fixed-point slab intervals per axis. Each input beat yields exactly one
// output beat, in order. One beat is taken per clock when the output side keeps
// up. There are three register stages (input register, product register, result
// register), and m_tvalid is driven by the result register. The middle stage is there
// because the four 16x11 signed multipliers get a stage of their own ahead of the
// compare stage. Stalls propagate back through
// the stages, so the full pipeline holds up to three beats. Box registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no beat
// is in flight; they reset to a box spanning 96..160 on both axes. On a miss
// every output field except hit is zero.

module ray_box_slab_hit
	import rbsh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// side_dist_x, side_dist_y, delta_x, delta_y, step_x_negative,
	// step_y_negative, dir_x_zero, dir_y_zero, rel_pos_x, rel_pos_y, 4 zero bits
	input  logic [S_DATA_W-1:0]   s_tdata,
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// hit, entry_dist, hit_side, face_low, face_shift, 1 zero bit
	output logic [M_DATA_W-1:0]   m_tdata,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BOX_W-1:0]      cfg_data
);

	// box registers
	logic [BOX_W-1:0] box_x_low_q;
	logic [BOX_W-1:0] box_x_high_q;
	logic [BOX_W-1:0] box_y_low_q;
	logic [BOX_W-1:0] box_y_high_q;

	// stage valids and flow control
	logic      valid_s1;
	logic      valid_s2;
	logic      out_valid_q;
	logic      out_free;
	logic      s2_free;

	// payload registers
	in_item_t  item_s1;
	slab_pre_t pre_x_s2;
	slab_pre_t pre_y_s2;
	logic [DIST_W-1:0] side_x_s2;
	logic [DIST_W-1:0] side_y_s2;
	out_item_t out_q;

	// combinational values
	slab_pre_t pre_x;
	slab_pre_t pre_y;
	slab_t     res_x;
	slab_t     res_y;
	out_item_t result;
	logic [DIST_W-1:0] ent;
	logic [DIST_W-1:0] ext;
	logic              side_sel;
	logic signed [BOX_W:0] width;
	logic [BOX_W-1:0]  width_c;
	logic [SHIFT_W-1:0] shift;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_low_q  <= BOX_LOW_RST;
			box_x_high_q <= BOX_HIGH_RST;
			box_y_low_q  <= BOX_LOW_RST;
			box_y_high_q <= BOX_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOX_X_LOW:  box_x_low_q  <= cfg_data;
				CFG_BOX_X_HIGH: box_x_high_q <= cfg_data;
				CFG_BOX_Y_LOW:  box_y_low_q  <= cfg_data;
				CFG_BOX_Y_HIGH: box_y_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// each stage moves on when the one after it is empty or draining
	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	assign s_tready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (out_free)
				out_valid_q <= valid_s2;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
	end

	// stage 1 logic: face distance products per axis
	rbsh_slab_pre u_pre_x (
		.delta         (item_s1.delta_x),
		.step_negative (item_s1.step_x_negative),
		.dir_zero      (item_s1.dir_x_zero),
		.rel_pos       (item_s1.rel_pos_x),
		.box_low       (box_x_low_q),
		.box_high      (box_x_high_q),
		.pre           (pre_x)
	);

	rbsh_slab_pre u_pre_y (
		.delta         (item_s1.delta_y),
		.step_negative (item_s1.step_y_negative),
		.dir_zero      (item_s1.dir_y_zero),
		.rel_pos       (item_s1.rel_pos_y),
		.box_low       (box_y_low_q),
		.box_high      (box_y_high_q),
		.pre           (pre_y)
	);

	// stage 2: product register
	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			pre_x_s2  <= pre_x;
			pre_y_s2  <= pre_y;
			side_x_s2 <= item_s1.side_dist_x;
			side_y_s2 <= item_s1.side_dist_y;
		end
	end

	// stage 2 logic: per-axis intervals
	rbsh_slab_cmp u_cmp_x (
		.side_dist (side_x_s2),
		.pre       (pre_x_s2),
		.res       (res_x)
	);

	rbsh_slab_cmp u_cmp_y (
		.side_dist (side_y_s2),
		.pre       (pre_y_s2),
		.res       (res_y)
	);

	// interval overlap; a tie between entry and exit still hits
	assign ent      = (res_x.dist_in > res_y.dist_in) ? res_x.dist_in : res_y.dist_in;
	assign ext      = (res_x.dist_out < res_y.dist_out) ? res_x.dist_out : res_y.dist_out;
	assign side_sel = !(res_x.dist_in > res_y.dist_in);

	// an x face spans the y extent of the box and vice versa
	always_comb begin
		if (side_sel)
			width = $signed({1'b0, box_x_high_q}) - $signed({1'b0, box_x_low_q});
		else
			width = $signed({1'b0, box_y_high_q}) - $signed({1'b0, box_y_low_q});
	end

	// empty or inverted box is treated as width one
	assign width_c = (width < 1) ? BOX_W'(1) : width[BOX_W-1:0];

	// shift brings the width up to a full face
	always_comb begin
		shift = '0;
		if (!width_c[BOX_W-1]) begin
			for (int i = 0; i < BOX_W-1; i++) begin
				if (width_c[i])
					shift = SHIFT_W'(BOX_W-1-i);
			end
		end
	end

	always_comb begin
		result = '0;
		if (res_x.ok && res_y.ok && (ent <= ext)) begin
			result.hit        = 1'b1;
			result.entry_dist = ent;
			result.hit_side   = side_sel;
			result.face_low   = side_sel ? box_x_low_q : box_y_low_q;
			result.face_shift = shift;
		end
	end

	// stage 3: result register
	always_ff @(posedge clk) begin
		if (valid_s2 && out_free)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-$bits(out_item_t)){1'b0}}, out_q};

	// a miss carries nothing but a cleared hit
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.hit |-> (out_q.entry_dist == '0) && !out_q.hit_side &&
			(out_q.face_low == '0) && (out_q.face_shift == '0))
		else $error("miss beat with nonzero fields");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.face_shift <= SHIFT_W'(BOX_W-1))
		else $error("face shift beyond full scale");

	// a stalled stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1)
		else $error("stage 1 beat dropped under stall");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(pre_x_s2) && $stable(pre_y_s2))
		else $error("stage 2 beat lost under stall");

endmodule
